FILE: src/bctm_pkg.sv
package bctm_pkg;

  localparam int COORD_BITS  = 16;
  localparam int OFFSET_BITS = 48;
  localparam int SIZE_W      = 9;
  localparam int STRIDE_W    = 32;
  localparam int IDX_W       = 16;
  localparam int SUM_W       = COORD_BITS + 1;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  typedef enum logic [CFG_AW-1:0] {
    REG_GRID_ROWS  = 4'd0,
    REG_GRID_COLS  = 4'd1,
    REG_ROW_OFFSET = 4'd2,
    REG_COL_OFFSET = 4'd3,
    REG_ROW_STRIDE = 4'd4,
    REG_COL_STRIDE = 4'd5,
    REG_VP_ROWS    = 4'd6,
    REG_VP_COLS    = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] tile_row;
    logic [COORD_BITS-1:0] tile_col;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]       owner_rank;
    logic [IDX_W-1:0]       vp_index;
    logic [OFFSET_BITS-1:0] byte_offset;
  } out_t;

endpackage

FILE: src/bctm_div.sv
module bctm_div
  import bctm_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic [SUM_W-1:0]  quotient,
  output logic [SIZE_W-1:0] remainder
);

  logic [SIZE_W-1:0] rem_r   [SUM_W];
  logic [SIZE_W-1:0] rem_nxt [SUM_W];
  logic [SUM_W-1:0]  dq_r    [SUM_W];
  logic [SUM_W-1:0]  dq_nxt  [SUM_W];

  for (genvar s = 0; s < SUM_W; s++) begin : g_stage
    logic [SIZE_W-1:0] src_rem;
    logic [SUM_W-1:0]  src_dq;
    logic [SIZE_W:0]   trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign src_rem = '0;
      assign src_dq  = dividend;
    end else begin : g_rest
      assign src_rem = rem_r[s-1];
      assign src_dq  = dq_r[s-1];
    end

    always_comb begin
      trial      = {src_rem, src_dq[SUM_W-1]};
      ge         = (trial >= {1'b0, divisor});
      rem_nxt[s] = ge ? SIZE_W'(trial - {1'b0, divisor}) : SIZE_W'(trial);
      dq_nxt[s]  = {src_dq[SUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        dq_r[s]  <= dq_nxt[s];
      end
    end
  end

  assign quotient  = dq_r[SUM_W-1];
  assign remainder = rem_r[SUM_W-1];

endmodule

FILE: src/block_cyclic_tile_mapper_unit.sv
// Block-cyclic tile mapper. Each transaction carries a tile coordinate and
// returns the owning rank, the virtual-processor index on that rank and the
// tile's byte offset in local storage. One transaction enters per cycle while
// the pipeline is not frozen: an offset-add stage feeds two chained pairs of
// restoring dividers that retire one quotient bit per stage, followed by a
// multiply stage and a sum stage. A stall on a valid result freezes the whole
// pipeline and is passed straight back to in_stall.
// Write configuration only while no transaction is in flight; sizes of zero
// act as one.
module block_cyclic_tile_mapper_unit
  import bctm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int DEPTH = 2 * SUM_W + 3;
  localparam int PW    = SUM_W + STRIDE_W;

  typedef struct packed {
    logic [SUM_W-1:0]  qm;
    logic [SUM_W-1:0]  qn;
    logic [SIZE_W-1:0] rm;
    logic [SIZE_W-1:0] rn;
  } mid_t;

  logic [SIZE_W-1:0]     grid_rows_r, grid_cols_r, vp_rows_r, vp_cols_r;
  logic [COORD_BITS-1:0] row_off_r, col_off_r;
  logic [STRIDE_W-1:0]   row_stride_r, col_stride_r;
  logic [SIZE_W-1:0]     p_eff, q_eff, vp_eff, vq_eff;

  logic                  adv;
  logic                  vld_r [DEPTH];
  logic [SUM_W-1:0]      m_r, n_r;
  logic [SUM_W-1:0]      qm_a, qn_a, qm_b, qn_b;
  logic [SIZE_W-1:0]     rm_a, rn_a, rvm_b, rvn_b;
  mid_t                  dly_r [SUM_W];
  mid_t                  mid_a;

  logic [2*SIZE_W-1:0]   rank_prod_r, vpi_prod_r;
  logic [SIZE_W-1:0]     rn_r, rvm_r;
  logic [PW-1:0]         col_prod_r, row_prod_r;
  logic [PW:0]           off_sum;
  out_t                  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= SIZE_W'(1);
      grid_cols_r  <= SIZE_W'(1);
      vp_rows_r    <= SIZE_W'(1);
      vp_cols_r    <= SIZE_W'(1);
      row_off_r    <= '0;
      col_off_r    <= '0;
      row_stride_r <= '0;
      col_stride_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_ROWS:  grid_rows_r  <= cfg_wdata[SIZE_W-1:0];
        REG_GRID_COLS:  grid_cols_r  <= cfg_wdata[SIZE_W-1:0];
        REG_ROW_OFFSET: row_off_r    <= cfg_wdata[COORD_BITS-1:0];
        REG_COL_OFFSET: col_off_r    <= cfg_wdata[COORD_BITS-1:0];
        REG_ROW_STRIDE: row_stride_r <= cfg_wdata[STRIDE_W-1:0];
        REG_COL_STRIDE: col_stride_r <= cfg_wdata[STRIDE_W-1:0];
        REG_VP_ROWS:    vp_rows_r    <= cfg_wdata[SIZE_W-1:0];
        REG_VP_COLS:    vp_cols_r    <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign p_eff  = (grid_rows_r == '0) ? SIZE_W'(1) : grid_rows_r;
  assign q_eff  = (grid_cols_r == '0) ? SIZE_W'(1) : grid_cols_r;
  assign vp_eff = (vp_rows_r == '0) ? SIZE_W'(1) : vp_rows_r;
  assign vq_eff = (vp_cols_r == '0) ? SIZE_W'(1) : vp_cols_r;

  assign adv      = !vld_r[DEPTH-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r <= SUM_W'(in_data.tile_row) + SUM_W'(row_off_r);
      n_r <= SUM_W'(in_data.tile_col) + SUM_W'(col_off_r);
    end
  end

  bctm_div u_div_m (.clk(clk), .en(adv), .dividend(m_r), .divisor(p_eff),
                    .quotient(qm_a), .remainder(rm_a));
  bctm_div u_div_n (.clk(clk), .en(adv), .dividend(n_r), .divisor(q_eff),
                    .quotient(qn_a), .remainder(rn_a));

  bctm_div u_div_vm (.clk(clk), .en(adv), .dividend(qm_a), .divisor(vp_eff),
                     .quotient(qm_b), .remainder(rvm_b));
  bctm_div u_div_vn (.clk(clk), .en(adv), .dividend(qn_a), .divisor(vq_eff),
                     .quotient(qn_b), .remainder(rvn_b));

  assign mid_a = '{qm: qm_a, qn: qn_a, rm: rm_a, rn: rn_a};

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= mid_a;
      for (int i = 1; i < SUM_W; i++) dly_r[i] <= dly_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rank_prod_r <= dly_r[SUM_W-1].rm * q_eff;
      vpi_prod_r  <= rvn_b * vp_eff;
      col_prod_r  <= PW'(dly_r[SUM_W-1].qn) * PW'(col_stride_r);
      row_prod_r  <= PW'(dly_r[SUM_W-1].qm) * PW'(row_stride_r);
      rn_r        <= dly_r[SUM_W-1].rn;
      rvm_r       <= rvm_b;
    end
  end

  assign off_sum = (PW+1)'(col_prod_r) + (PW+1)'(row_prod_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.owner_rank  <= IDX_W'((2*SIZE_W+1)'(rank_prod_r) + (2*SIZE_W+1)'(rn_r));
      out_r.vp_index    <= IDX_W'((2*SIZE_W+1)'(vpi_prod_r) + (2*SIZE_W+1)'(rvm_r));
      out_r.byte_offset <= OFFSET_BITS'(off_sum);
    end
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = out_r;

  logic unused_q;
  assign unused_q = ^{qm_b, qn_b};

endmodule

FILE: src/bctm_chk.sv
module bctm_chk
  import bctm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_stall_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while pipeline frozen");

endmodule

bind block_cyclic_tile_mapper_unit bctm_chk u_bctm_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

FILE: tb/tb_checker.sv
`timescale 1ns / 100ps

module tb_checker
  import bctm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_t              out_data,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                mapped_count
);

  logic [8:0]  grid_p, grid_q, vp_r, vp_c;
  logic [15:0] row_off, col_off;
  logic [31:0] row_stride, col_stride;
  out_t        tile_map_q[$];

  function automatic out_t map_tile(in_t t);
    logic [63:0] p, q, vr, vc, m, n, lm, ln, rank, vpi, off;
    out_t r;
    p = (grid_p == 0) ? 64'd1 : 64'(grid_p);
    q = (grid_q == 0) ? 64'd1 : 64'(grid_q);
    vr = (vp_r == 0) ? 64'd1 : 64'(vp_r);
    vc = (vp_c == 0) ? 64'd1 : 64'(vp_c);
    m = 64'(t.tile_row) + 64'(row_off);
    n = 64'(t.tile_col) + 64'(col_off);
    lm = m / p;
    ln = n / q;
    rank = (m % p) * q + (n % q);
    vpi = (ln % vc) * vr + (lm % vr);
    off = ln * 64'(col_stride) + lm * 64'(row_stride);
    r.owner_rank = rank[15:0];
    r.vp_index = vpi[15:0];
    r.byte_offset = off[47:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      grid_p <= 9'd1;
      grid_q <= 9'd1;
      vp_r <= 9'd1;
      vp_c <= 9'd1;
      row_off <= '0;
      col_off <= '0;
      row_stride <= '0;
      col_stride <= '0;
      fail_count <= 0;
      mapped_count <= 0;
      tile_map_q.delete();
    end else begin
      if (in_valid && !in_stall) tile_map_q.push_back(map_tile(in_data));
      if (out_valid && !out_stall) begin
        mapped_count <= mapped_count + 1;
        if (tile_map_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected transaction %p", out_data);
        end else begin
          want = tile_map_q.pop_front();
          if (want !== out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp rank %0d vp %0d off %h, got rank %0d vp %0d off %h",
                       want.owner_rank, want.vp_index, want.byte_offset,
                       out_data.owner_rank, out_data.vp_index, out_data.byte_offset);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_ROWS:  grid_p <= cfg_wdata[8:0];
          REG_GRID_COLS:  grid_q <= cfg_wdata[8:0];
          REG_ROW_OFFSET: row_off <= cfg_wdata[15:0];
          REG_COL_OFFSET: col_off <= cfg_wdata[15:0];
          REG_ROW_STRIDE: row_stride <= cfg_wdata;
          REG_COL_STRIDE: col_stride <= cfg_wdata;
          REG_VP_ROWS:    vp_r <= cfg_wdata[8:0];
          REG_VP_COLS:    vp_c <= cfg_wdata[8:0];
          default: ;
        endcase
      end
    end
  end

  assign pending = tile_map_q.size();

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bctm_pkg::*;

  localparam int LATENCY = 2 * (COORD_BITS + 1) + 3;
  localparam int CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  int                fail_count, pending, mapped_count;
  int                send_idle_pct = 0, recv_idle_pct = 0;
  bit                hold_off = 1'b0;
  int                cycles = 0;
  int                config_count = 0;

  always #6 clk = ~clk;

  block_cyclic_tile_mapper_unit i_dut (.*);

  tb_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_tile(logic [15:0] r, logic [15:0] c);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{tile_row: r, tile_col: c};
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [8:0] pick_size();
    case ($urandom_range(5))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'(511);
      default: return 9'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic configure(logic [8:0] p, logic [8:0] q, logic [15:0] ro,
                           logic [15:0] co, logic [31:0] rs, logic [31:0] cs,
                           logic [8:0] vr, logic [8:0] vc);
    write_reg(REG_GRID_ROWS, 32'(p));
    write_reg(REG_GRID_COLS, 32'(q));
    write_reg(REG_ROW_OFFSET, 32'(ro));
    write_reg(REG_COL_OFFSET, 32'(co));
    write_reg(REG_ROW_STRIDE, rs);
    write_reg(REG_COL_STRIDE, cs);
    write_reg(REG_VP_ROWS, 32'(vr));
    write_reg(REG_VP_COLS, 32'(vc));
    config_count++;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_tile(pick_coord(), pick_coord());
    idle_input();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tile(16'd0, 16'd0);
    send_tile(16'hffff, 16'hffff);
    idle_input();
    drain();
    configure(9'd0, 9'd0, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 9'd0, 9'd0);
    send_tile(16'hffff, 16'hffff);
    send_tile(16'd0, 16'd0);
    idle_input();
    drain();
    configure(9'(511), 9'(511), 16'd0, 16'd0, 32'd1, 32'd4096, 9'(511), 9'(511));
    send_tile(16'hffff, 16'hffff);
    send_tile(16'd510, 16'd511);
    send_tile(16'h5555, 16'haaaa);
    send_tile(16'haaaa, 16'h5555);
    idle_input();
    drain();
    configure(9'd3, 9'd5, 16'd7, 16'd2, 32'h10000, 32'h800000, 9'd256, 9'd256);
    for (int i = 0; i < 12; i++) send_tile(16'(i * 37), 16'(i * 1021));
    idle_input();
    drain();
    write_reg(cfg_reg_t'(4'd9), 32'd1);
    write_reg(cfg_reg_t'(4'd15), 32'hffffffff);
    send_tile(16'd100, 16'd200);
    idle_input();

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      configure(pick_size(), pick_size(), 16'($urandom), 16'($urandom), $urandom,
                $urandom, pick_size(), pick_size());
      if (ph < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 88;
      end else if (ph < 6) begin
        send_idle_pct = 88;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 7) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
          random_phase(60);
        join
        drain();
        random_phase(40);
      end else begin
        random_phase(45);
        drain();
        random_phase(55);
      end
    end
    drain();

    $display("covered %0d configurations and %0d results, incl. full-pipe stall",
             config_count, mapped_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("failures: %0d", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bctm_pkg.sv
src/bctm_div.sv
src/block_cyclic_tile_mapper_unit.sv
src/bctm_chk.sv
tb/tb_checker.sv
tb/tb_top.sv
